FILE: rtl/hbw_pkg.sv
// ----------------------------------------------------------------------------
// hbw_pkg
// Shared widths, request and register codes, and pipeline side-band types
// for the homography bilinear warp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hbw_pkg;

  localparam int COEF_W      = 48;
  localparam int PIX_W       = 10;
  localparam int CH_W        = 8;
  localparam int IN_CH       = 3;
  localparam int PROD_W      = 59;
  localparam int SUM_W       = 61;
  localparam int MAG_W       = 61;
  localparam int FRAC_W      = 8;
  localparam int QUO_W       = MAG_W + FRAC_W;
  localparam int FX_W        = FRAC_W + 1;
  localparam int COEFF_COUNT = 9;
  localparam int CFG_W       = 11;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_COEFF = 2'd1;
  localparam logic [1:0] REQ_MAP   = 2'd2;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  typedef struct packed {
    logic                    map_v;
    logic                    load_v;
    logic                    fault;
    logic                    neg_u;
    logic                    neg_v;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic [IN_CH*CH_W-1:0]   data;
  } hbw_tag_t;

  typedef struct packed {
    logic [CH_W-1:0] p00;
    logic [CH_W-1:0] p01;
    logic [CH_W-1:0] p10;
    logic [CH_W-1:0] p11;
  } hbw_quad_t;

  typedef struct packed {
    logic map_v;
    logic fault;
  } hbw_side_t;

endpackage

`default_nettype wire

FILE: rtl/hbw_bank.sv
// ----------------------------------------------------------------------------
// hbw_bank
// One bank of the frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hbw_bank #(
  parameter int AW = 18,
  parameter int DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/hbw_div.sv
// ----------------------------------------------------------------------------
// hbw_div
// Pipelined restoring divider: two numerators over a shared divisor, one
// quotient bit per stage, with the item side-band carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module hbw_div import hbw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [MAG_W-1:0] num_u_i,
  input  wire logic [MAG_W-1:0] num_v_i,
  input  wire logic [MAG_W-1:0] den_i,
  input  wire hbw_tag_t         tag_i,
  output logic      [QUO_W-1:0] quo_u_o,
  output logic      [QUO_W-1:0] quo_v_o,
  output hbw_tag_t              tag_o
);

  logic [MAG_W-1:0] rem_u_q [QUO_W];
  logic [MAG_W-1:0] rem_v_q [QUO_W];
  logic [QUO_W-1:0] nq_u_q  [QUO_W];
  logic [QUO_W-1:0] nq_v_q  [QUO_W];
  logic [MAG_W-1:0] den_q   [QUO_W];
  hbw_tag_t         tag_q   [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [MAG_W-1:0] rem_u, rem_v, den;
    logic [QUO_W-1:0] nq_u, nq_v;
    hbw_tag_t         tag;
    logic [MAG_W:0]   t_u, t_v;
    logic             ge_u, ge_v;

    if (i == 0) begin : g_first
      assign rem_u = '0;
      assign rem_v = '0;
      assign nq_u  = {num_u_i, {FRAC_W{1'b0}}};
      assign nq_v  = {num_v_i, {FRAC_W{1'b0}}};
      assign den   = den_i;
      assign tag   = tag_i;
    end else begin : g_next
      assign rem_u = rem_u_q[i-1];
      assign rem_v = rem_v_q[i-1];
      assign nq_u  = nq_u_q[i-1];
      assign nq_v  = nq_v_q[i-1];
      assign den   = den_q[i-1];
      assign tag   = tag_q[i-1];
    end

    assign t_u  = {rem_u, nq_u[QUO_W-1]};
    assign t_v  = {rem_v, nq_v[QUO_W-1]};
    assign ge_u = t_u >= {1'b0, den};
    assign ge_v = t_v >= {1'b0, den};

    always_ff @(posedge clk_i) begin
      rem_u_q[i] <= ge_u ? MAG_W'(t_u - {1'b0, den}) : MAG_W'(t_u);
      rem_v_q[i] <= ge_v ? MAG_W'(t_v - {1'b0, den}) : MAG_W'(t_v);
      nq_u_q[i]  <= {nq_u[QUO_W-2:0], ge_u};
      nq_v_q[i]  <= {nq_v[QUO_W-2:0], ge_v};
      den_q[i]   <= den;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[i] <= '0;
      end else begin
        tag_q[i] <= tag;
      end
    end
  end

  assign quo_u_o = nq_u_q[QUO_W-1];
  assign quo_v_o = nq_v_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/hbw_lane.sv
// ----------------------------------------------------------------------------
// hbw_lane
// One channel lane: row interpolation at 1/16 scale, then column
// interpolation, truncation and clamp to one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hbw_lane import hbw_pkg::*; (
  input  wire logic                   clk_i,
  input  wire hbw_quad_t              quad_i,
  input  wire logic signed [FX_W-1:0] fx_i,
  input  wire logic signed [FX_W-1:0] fy_i,
  output logic             [CH_W-1:0] pix_o
);

  localparam int ROW_W = 20;
  localparam int R_W   = 16;
  localparam int COL_W = 28;

  logic signed [ROW_W-1:0] wa, wb, s0, s1;
  logic signed [R_W-1:0]   r0_q, r1_q;
  logic signed [FX_W-1:0]  fy_q;
  logic signed [COL_W-1:0] wc, wd, t, o;
  logic        [CH_W-1:0]  pix_q;

  always_comb begin
    wb = ROW_W'(fx_i);
    wa = 20'sd256 - wb;
    s0 = wa * ROW_W'($signed({1'b0, quad_i.p00})) + wb * ROW_W'($signed({1'b0, quad_i.p01}));
    s1 = wa * ROW_W'($signed({1'b0, quad_i.p10})) + wb * ROW_W'($signed({1'b0, quad_i.p11}));
  end

  always_ff @(posedge clk_i) begin
    r0_q <= R_W'((s0 + ((s0 < 0) ? 20'sd15 : 20'sd0)) >>> 4);
    r1_q <= R_W'((s1 + ((s1 < 0) ? 20'sd15 : 20'sd0)) >>> 4);
    fy_q <= fy_i;
  end

  always_comb begin
    wc = COL_W'(fy_q);
    wd = 28'sd256 - wc;
    t  = wd * COL_W'(r0_q) + wc * COL_W'(r1_q);
    o  = (t + ((t < 0) ? 28'sd4095 : 28'sd0)) >>> 12;
  end

  always_ff @(posedge clk_i) begin
    if (o < 0) begin
      pix_q <= '0;
    end else if (o > 28'sd255) begin
      pix_q <= 8'd255;
    end else begin
      pix_q <= o[CH_W-1:0];
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

FILE: rtl/homography_bilinear_warp_unit.sv
// ----------------------------------------------------------------------------
// homography_bilinear_warp_unit
// Perspective warp with bilinear resampling over a four-bank frame store.
// Pipeline: multiply, sum and magnitude stages, the 69-stage divider, then
//   clamp, read, row, column and output registers ahead of the done strobe.
// Throughput: one item per cycle; busy stays low, loads and coefficient
//   writes give no result. The receiver cannot stall.
// Reset: pipeline cleared, registers 1024/1024/3; store and coefficients
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module homography_bilinear_warp_unit import hbw_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_CHANNELS = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [PIX_W-1:0]         pixel_x_i,
  input  wire logic [PIX_W-1:0]         pixel_y_i,
  input  wire logic [CH_W-1:0]          chan_a_in_i,
  input  wire logic [CH_W-1:0]          chan_b_in_i,
  input  wire logic [CH_W-1:0]          chan_c_in_i,
  input  wire logic [3:0]               coeff_index_i,
  input  wire logic signed [COEF_W-1:0] coeff_value_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic [CH_W-1:0]               chan_a_out_o,
  output logic [CH_W-1:0]               chan_b_out_o,
  output logic [CH_W-1:0]               chan_c_out_o,
  output logic                          divide_fault_o
);

  localparam int XW  = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
  localparam int YW  = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
  localparam int BAW = XW + YW - 2;
  localparam int NL  = (MAX_CHANNELS < IN_CH) ? MAX_CHANNELS : IN_CH;
  localparam int DW  = NL * CH_W;

  logic [CFG_W-1:0] width_q, height_q;
  logic [1:0]       count_q;
  logic [XW-1:0]    wm1;
  logic [YW-1:0]    hm1;

  logic signed [COEF_W-1:0] coef_q [COEFF_COUNT];

  logic                     accept;
  logic signed [PIX_W:0]    sx, sy;
  logic signed [PROD_W-1:0] prod_q [6];
  logic signed [COEF_W-1:0] off_q  [3];
  hbw_tag_t                 tag1_d, tag1_q, tag2_q, tag3_d, tag3_q;
  logic signed [SUM_W-1:0]  u2_q, v2_q, w2_q;
  logic [MAG_W-1:0]         mu_q, mv_q, mw_q;
  logic                     nu, nv, nw;

  logic [QUO_W-1:0]         quo_u, quo_v;
  hbw_tag_t                 dtag;

  logic [MAG_W-1:0]         mx, my;
  logic                     negx, negy;
  logic [XW-1:0]            xa_d, xb_d, xa_q, xb_q;
  logic [YW-1:0]            ya_d, yb_d, ya_q, yb_q;
  logic signed [FX_W-1:0]   fx_d, fy_d, fx_q, fy_q, rfx_q, rfy_q;
  logic [FX_W-1:0]          fxp, fyp;
  hbw_tag_t                 ctag_q;

  logic [XW-1:0]            ldx;
  logic [YW-1:0]            ldy;
  logic [DW-1:0]            bank_rd [4];
  logic [3:0]               rsel_q;
  hbw_side_t                rside_q, l1side_q, l2side_q;
  logic [CH_W-1:0]          lane_pix [IN_CH];
  logic [CH_W-1:0]          merge_d  [IN_CH];
  logic [CH_W-1:0]          out_q    [IN_CH];
  logic                     done_q, fault_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      count_q  <= 2'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:    width_q  <= cfg_data_i;
        CFG_HEIGHT:   height_q <= cfg_data_i;
        CFG_CHANNELS: count_q  <= cfg_data_i[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (int'(width_q) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      hm1 = '0;
    end else if (int'(height_q) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(height_q - 11'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_COEFF && int'(coeff_index_i) < COEFF_COUNT) begin
      coef_q[coeff_index_i] <= coeff_value_i;
    end
  end

  assign sx = $signed({1'b0, pixel_x_i});
  assign sy = $signed({1'b0, pixel_y_i});

  always_comb begin
    tag1_d        = '0;
    tag1_d.map_v  = accept && req_type_i == REQ_MAP;
    tag1_d.load_v = accept && req_type_i == REQ_LOAD && int'(pixel_x_i) < MAX_WIDTH
                    && int'(pixel_y_i) < MAX_HEIGHT;
    tag1_d.px     = pixel_x_i;
    tag1_d.py     = pixel_y_i;
    tag1_d.data   = {chan_c_in_i, chan_b_in_i, chan_a_in_i};
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= coef_q[0] * sx;
    prod_q[1] <= coef_q[1] * sy;
    prod_q[2] <= coef_q[3] * sx;
    prod_q[3] <= coef_q[4] * sy;
    prod_q[4] <= coef_q[6] * sx;
    prod_q[5] <= coef_q[7] * sy;
    off_q[0]  <= coef_q[2];
    off_q[1]  <= coef_q[5];
    off_q[2]  <= coef_q[8];
    u2_q      <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(off_q[0]);
    v2_q      <= SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]) + SUM_W'(off_q[1]);
    w2_q      <= SUM_W'(prod_q[4]) + SUM_W'(prod_q[5]) + SUM_W'(off_q[2]);
  end

  assign nu = u2_q[SUM_W-1];
  assign nv = v2_q[SUM_W-1];
  assign nw = w2_q[SUM_W-1];

  always_comb begin
    tag3_d       = tag2_q;
    tag3_d.fault = tag2_q.map_v && (w2_q == '0);
    tag3_d.neg_u = nu ^ nw;
    tag3_d.neg_v = nv ^ nw;
  end

  always_ff @(posedge clk_i) begin
    mu_q <= nu ? MAG_W'(-u2_q) : MAG_W'(u2_q);
    mv_q <= nv ? MAG_W'(-v2_q) : MAG_W'(v2_q);
    if (w2_q == '0) begin
      mw_q <= MAG_W'(1);
    end else begin
      mw_q <= nw ? MAG_W'(-w2_q) : MAG_W'(w2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      tag3_q <= tag3_d;
    end
  end

  hbw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .num_u_i (mu_q),
    .num_v_i (mv_q),
    .den_i   (mw_q),
    .tag_i   (tag3_q),
    .quo_u_o (quo_u),
    .quo_v_o (quo_v),
    .tag_o   (dtag)
  );

  always_comb begin
    mx   = quo_u[QUO_W-1:FRAC_W];
    my   = quo_v[QUO_W-1:FRAC_W];
    negx = dtag.neg_u && (mx != '0);
    negy = dtag.neg_v && (my != '0);
    fxp  = {1'b0, quo_u[FRAC_W-1:0]};
    fyp  = {1'b0, quo_v[FRAC_W-1:0]};
    fx_d = dtag.neg_u ? -$signed(fxp) : $signed(fxp);
    fy_d = dtag.neg_v ? -$signed(fyp) : $signed(fyp);
    if (negx) begin
      xa_d = '0;
      xb_d = '0;
    end else begin
      xa_d = (mx > MAG_W'(wm1)) ? wm1 : XW'(mx);
      xb_d = (mx >= MAG_W'(wm1)) ? wm1 : XW'(mx) + XW'(1);
    end
    if (negy) begin
      ya_d = '0;
      yb_d = '0;
    end else begin
      ya_d = (my > MAG_W'(hm1)) ? hm1 : YW'(my);
      yb_d = (my >= MAG_W'(hm1)) ? hm1 : YW'(my) + YW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q  <= xa_d;
    xb_q  <= xb_d;
    ya_q  <= ya_d;
    yb_q  <= yb_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    rfx_q <= fx_q;
    rfy_q <= fy_q;
    rsel_q <= {yb_q[0], ya_q[0], xb_q[0], xa_q[0]};
  end

  assign ldx = XW'(ctag_q.px);
  assign ldy = YW'(ctag_q.py);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0]  xs;
    logic [YW-1:0]  ys;
    logic           we;

    assign xs = (xa_q[0] == b[0]) ? xa_q : xb_q;
    assign ys = (ya_q[0] == b[1]) ? ya_q : yb_q;
    assign we = ctag_q.load_v && ldx[0] == b[0] && ldy[0] == b[1];

    hbw_bank #(.AW(BAW), .DW(DW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i ({ldy[YW-1:1], ldx[XW-1:1]}),
      .wdata_i (ctag_q.data[DW-1:0]),
      .raddr_i ({ys[YW-1:1], xs[XW-1:1]}),
      .rdata_o (bank_rd[b])
    );
  end

  for (genvar k = 0; k < IN_CH; k++) begin : g_lane
    if (k < NL) begin : g_on
      hbw_quad_t quad;

      assign quad.p00 = bank_rd[{rsel_q[2], rsel_q[0]}][k*CH_W +: CH_W];
      assign quad.p01 = bank_rd[{rsel_q[2], rsel_q[1]}][k*CH_W +: CH_W];
      assign quad.p10 = bank_rd[{rsel_q[3], rsel_q[0]}][k*CH_W +: CH_W];
      assign quad.p11 = bank_rd[{rsel_q[3], rsel_q[1]}][k*CH_W +: CH_W];

      hbw_lane u_lane (
        .clk_i  (clk_i),
        .quad_i (quad),
        .fx_i   (rfx_q),
        .fy_i   (rfy_q),
        .pix_o  (lane_pix[k])
      );

      assign merge_d[k] = (!l2side_q.fault && 2'(k) < count_q) ? lane_pix[k] : '0;
    end else begin : g_off
      assign lane_pix[k] = '0;
      assign merge_d[k]  = lane_pix[k];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= merge_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctag_q   <= '0;
      rside_q  <= '0;
      l1side_q <= '0;
      l2side_q <= '0;
      done_q   <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      ctag_q        <= dtag;
      rside_q.map_v <= ctag_q.map_v;
      rside_q.fault <= ctag_q.fault;
      l1side_q      <= rside_q;
      l2side_q      <= l1side_q;
      done_q        <= l2side_q.map_v;
      fault_q       <= l2side_q.map_v && l2side_q.fault;
    end
  end

  assign done_o         = done_q;
  assign divide_fault_o = fault_q;
  assign chan_a_out_o   = out_q[0];
  assign chan_b_out_o   = out_q[1];
  assign chan_c_out_o   = out_q[2];

  a_fault_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_fault_o |->
      chan_a_out_o == '0 && chan_b_out_o == '0 && chan_c_out_o == '0)
    else $error("fault pixel not zero");

  a_chan_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && count_q < 2'd3 |-> chan_c_out_o == '0)
    else $error("unused channel not zero");

  a_map_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctag_q.map_v |-> ##4 done_o)
    else $error("map item lost after clamp stage");

endmodule

`default_nettype wire
